@@ design/dtq_pkg.sv @@
// dtq_pkg: character codes, format constants and a constant power-of-ten function for the
// decimal text to fixed-point converter
// no dependencies
package dtq_pkg;

    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    localparam int INT_MAX   = 127;
    localparam int INT_BITS  = 7;
    localparam int OUT_WIDTH = 16;

    // elaboration-time only, used to size the fraction datapath
    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int k = 0; k < n; k++) begin
            p = p * 10;
        end
        return p;
    endfunction

endpackage

@@ design/decimal_text_to_q7_8_top.sv @@
// decimal_text_to_q7_8_top: parses a decimal token one character per
// transaction and returns its signed fixed-point value
// depends on dtq_pkg
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_character[7:0], i_last
//  out     | output    | o_out_valid / i_out_stall | o_fixed_value[15:0], o_status
//
//  characters are taken one per cycle while the parser accumulates; after
//  the last one the fraction is divided by 10^digits in a restoring divider,
//  one quotient bit per cycle
//  the input stalls while the divider runs and while the result waits to load
//  a finished result sits in the output register, so the next token is taken
//  while the previous result is still stalled
//  reset is synchronous, active low, and returns the parser to its start phase
module decimal_text_to_q7_8_top #(
    parameter int FRAC_BITS       = 8,
    parameter int MAX_FRAC_DIGITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_character,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_fixed_value,
    output logic        o_status
);
    import dtq_pkg::*;

    // fraction accumulator and divisor width: holds values up to 10^MAX_FRAC_DIGITS
    localparam int FW      = $clog2(pow10(MAX_FRAC_DIGITS));
    localparam int CW      = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int QCW     = $clog2(FRAC_BITS + 1);
    localparam int MW      = INT_BITS + FRAC_BITS;
    localparam int EW      = (MW > OUT_WIDTH) ? MW : OUT_WIDTH;
    localparam int INT_NXW = INT_BITS + 4;

    // parser phases
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // sequencer states
    localparam logic [1:0] S_ACC  = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [1:0]          r_phase, n_phase;
    logic                r_neg, n_neg;
    logic [INT_BITS-1:0] r_int, n_int;
    logic                r_rerr, n_rerr;
    // fraction accumulator, reused as the divider remainder
    logic [FW-1:0]       r_frac, n_frac;
    // running power of ten, the divisor
    logic [FW-1:0]       r_scale, n_scale;
    logic [CW-1:0]       r_fcnt, n_fcnt;
    logic [QCW-1:0]      r_bit, n_bit;
    logic [FRAC_BITS-1:0] r_quot, n_quot;

    logic                r_out_valid;
    logic [15:0]         r_out_value;
    logic                r_out_status;

    logic                in_acc;
    logic                out_free;
    logic [3:0]          digit;
    logic                is_digit;
    logic                is_sep;
    logic [INT_NXW-1:0]  int_next;
    logic [FW+3:0]       frac_next;
    logic [FW+3:0]       scale_next;
    logic [FW:0]         rem_dbl;
    logic [FW:0]         rem_sub;
    logic                q_bit;
    logic [MW-1:0]       mag;
    logic [EW-1:0]       mag_ext;
    logic [EW-1:0]       signed_val;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign digit    = i_character[3:0];
    assign is_digit = (i_character >= CHR_ZERO) && (i_character <= CHR_NINE);
    assign is_sep   = (i_character == CHR_DOT) || (i_character == CHR_COMMA);

    // x*10 + d as two shifted adds
    assign int_next   = {r_int, 3'b000} + {2'b00, r_int, 1'b0}
                      + INT_NXW'(digit);
    assign frac_next  = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0}
                      + (FW+4)'(digit);
    assign scale_next = {1'b0, r_scale, 3'b000} + {3'b000, r_scale, 1'b0};

    // one restoring division step
    assign rem_dbl = {r_frac, 1'b0};
    assign rem_sub = rem_dbl - {1'b0, r_scale};
    assign q_bit   = (rem_dbl >= {1'b0, r_scale});

    // integer part sits directly above the quotient bits
    assign mag        = {r_int, r_quot};
    assign mag_ext    = EW'(mag);
    assign signed_val = r_neg ? (EW'(0) - mag_ext) : mag_ext;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_int   = r_int;
        n_rerr  = r_rerr;
        n_frac  = r_frac;
        n_scale = r_scale;
        n_fcnt  = r_fcnt;
        n_bit   = r_bit;
        n_quot  = r_quot;

        unique case (r_state)
            S_ACC: begin
                if (in_acc) begin
                    unique case (r_phase)
                        PH_START: begin
                            if (i_character == CHR_MINUS) begin
                                n_neg   = 1'b1;
                                n_phase = PH_INT;
                            end else if (is_digit) begin
                                if (int_next > INT_NXW'(INT_MAX)) begin
                                    n_rerr = 1'b1;
                                end else begin
                                    n_int = int_next[INT_BITS-1:0];
                                end
                                n_phase = PH_INT;
                            end else if (is_sep) begin
                                n_phase = PH_FRAC;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                        PH_INT: begin
                            if (is_digit) begin
                                if (int_next > INT_NXW'(INT_MAX)) begin
                                    n_rerr = 1'b1;
                                end else begin
                                    n_int = int_next[INT_BITS-1:0];
                                end
                            end else if (is_sep) begin
                                n_phase = PH_FRAC;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                        PH_FRAC: begin
                            if (is_digit) begin
                                // digits past the limit are dropped silently
                                if (r_fcnt < CW'(MAX_FRAC_DIGITS)) begin
                                    n_frac  = frac_next[FW-1:0];
                                    n_scale = scale_next[FW-1:0];
                                    n_fcnt  = r_fcnt + CW'(1);
                                end
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (i_last) begin
                        n_state = S_DIV;
                        n_bit   = '0;
                    end
                end
            end
            S_DIV: begin
                if (q_bit) begin
                    n_frac = rem_sub[FW-1:0];
                end else begin
                    n_frac = rem_dbl[FW-1:0];
                end
                n_quot = FRAC_BITS'({r_quot, q_bit});
                n_bit  = r_bit + QCW'(1);
                if (r_bit == QCW'(FRAC_BITS - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    // result leaves for the output register, parser starts over
                    n_state = S_ACC;
                    n_phase = PH_START;
                    n_neg   = 1'b0;
                    n_int   = '0;
                    n_rerr  = 1'b0;
                    n_frac  = '0;
                    n_scale = FW'(1);
                    n_fcnt  = '0;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_int   <= '0;
            r_rerr  <= 1'b0;
            r_frac  <= '0;
            r_scale <= FW'(1);
            r_fcnt  <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_int   <= n_int;
            r_rerr  <= n_rerr;
            r_frac  <= n_frac;
            r_scale <= n_scale;
            r_fcnt  <= n_fcnt;
            r_bit   <= n_bit;
        end
    end

    // quotient shift register, no reset needed
    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_LOAD && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && out_free) begin
            r_out_value  <= r_rerr ? 16'd0 : signed_val[15:0];
            r_out_status <= r_rerr;
        end
    end

    assign o_in_stall    = (r_state != S_ACC);
    assign o_out_valid   = r_out_valid;
    assign o_fixed_value = r_out_value;
    assign o_status      = r_out_status;

    // divider remainder stays below the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_frac < r_scale))
        else $error("remainder not below divisor");

    // digit count never passes its limit
    a_fcnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= CW'(MAX_FRAC_DIGITS))
        else $error("fraction digit count over limit");

    // last character starts the divider
    a_last_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=> (r_state == S_DIV))
        else $error("divider not started after last character");

    // a new result only appears out of the load state
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_LOAD))
        else $error("result without load");

    // out-of-range results carry zero
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_fixed_value == 16'sd0))
        else $error("out-of-range result not zero");

endmodule
